FILE: rtl/wps_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the wildcard pattern scan.
// No dependencies; imported by every module of the block.
package wps_pkg;

  // Longest window the block keeps, and signature bytes held in configuration
  localparam int SIG_MAX  = 16;
  localparam int SIG_HELD = 16;
  localparam int CELLS    = (SIG_MAX < SIG_HELD) ? SIG_MAX : SIG_HELD;
  localparam int SIG_IDX_W = $clog2(SIG_HELD);
  localparam int LEN_W    = 5;
  localparam int ADDR_W   = 64;

  // Configuration register indexes (byte address 8 * index)
  localparam logic [2:0] REG_SIG_LOW  = 3'd0;
  localparam logic [2:0] REG_SIG_HIGH = 3'd1;
  localparam logic [2:0] REG_WILDCARD = 3'd2;
  localparam logic [2:0] REG_LENGTH   = 3'd3;
  localparam logic [2:0] REG_DESCEND  = 3'd4;
  localparam logic [2:0] REG_BASE     = 3'd5;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_word_t;

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] match_address;
  } out_word_t;

  typedef struct packed {
    logic [63:0]       signature_low;
    logic [63:0]       signature_high;
    logic [15:0]       wildcard_mask;
    logic [LEN_W-1:0]  signature_length;
    logic              scan_descending;
    logic [ADDR_W-1:0] base_address;
  } cfg_t;

  // Per-cycle control shared by every cell of the window
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

endpackage

FILE: rtl/wps_cell.sv
`timescale 1ns / 1ps
// One window cell: holds one byte and compares the byte it takes in.
// Depends on wps_pkg.
module wps_cell
  import wps_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  logic [7:0] byte_i,
  input  logic [7:0] sig_i,
  input  logic       wild_i,
  input  logic       use_i,
  output logic [7:0] byte_o,
  output logic       match_o
);

  logic [7:0] byte_q, byte_d;

  // Compare the byte this cell latches on the current shift
  assign match_o = !use_i || wild_i || (byte_i == sig_i);

  // Clear wins over shift
  always_comb begin
    byte_d = byte_q;
    if (ctrl_i.clear) begin
      byte_d = 8'd0;
    end else if (ctrl_i.shift) begin
      byte_d = byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= 8'd0;
    end else begin
      byte_q <= byte_d;
    end
  end

  assign byte_o = byte_q;

endmodule

FILE: rtl/wps_cfg_regs.sv
`timescale 1ns / 1ps
// APB-style configuration registers of the pattern scan.
// Depends on wps_pkg.
module wps_cfg_regs
  import wps_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  cfg_t       cfg_q, cfg_d;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign wr_en   = psel && penable && pwrite && pready;

  // Write the addressed register; unknown indexes drop the word
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        REG_SIG_LOW:  cfg_d.signature_low    = pwdata;
        REG_SIG_HIGH: cfg_d.signature_high   = pwdata;
        REG_WILDCARD: cfg_d.wildcard_mask    = pwdata[15:0];
        REG_LENGTH:   cfg_d.signature_length = pwdata[LEN_W-1:0];
        REG_DESCEND:  cfg_d.scan_descending  = pwdata[0];
        REG_BASE:     cfg_d.base_address     = pwdata[ADDR_W-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  // Reset every register to zero except the length, which starts at one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= {64'd0, 64'd0, 16'd0, LEN_W'(1), 1'b0, {ADDR_W{1'b0}}};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read back the addressed register
  always_comb begin
    case (reg_idx)
      REG_SIG_LOW:  prdata = cfg_q.signature_low;
      REG_SIG_HIGH: prdata = cfg_q.signature_high;
      REG_WILDCARD: prdata = {48'd0, cfg_q.wildcard_mask};
      REG_LENGTH:   prdata = {{(64-LEN_W){1'b0}}, cfg_q.signature_length};
      REG_DESCEND:  prdata = {63'd0, cfg_q.scan_descending};
      REG_BASE:     prdata = cfg_q.base_address;
      default:      prdata = 64'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/wildcard_pattern_scan.sv
`timescale 1ns / 1ps
// Top level of the wildcard pattern scan: window cell chain, search state,
// output register. Depends on wps_pkg, wps_cell and wps_cfg_regs.
//
//   channel | direction | handshake                  | word
//   --------+-----------+----------------------------+---------------------
//   in      | input     | in_valid_i / in_ready_o    | in_word_t
//   out     | output    | out_valid_o / out_ready_i  | out_word_t
//   cfg     | input     | psel, penable, pwrite      | paddr, pwdata/prdata
//
// One byte is taken every cycle unless the input stalls; the compare over the whole cell chain and
// the address add finish in the cycle of acceptance.
// A result sits in the output register from the cycle after its byte.
// The input stalls only while the output register is full and not taken.
// Reset clears the window, the search state and the output valid, and sets
// the registers to their reset values; no clearing pass follows.
module wildcard_pattern_scan
  import wps_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_word_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_word_t   out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  cfg_t              cfg;
  cell_ctrl_t        cell_ctrl;
  logic [127:0]      sig_all;
  logic [LEN_W-1:0]  len_used;
  logic [7:0]        chain [CELLS+1];
  logic [CELLS-1:0]  cell_match;

  logic [LEN_W-1:0]  seen_q, seen_d, seen_next;
  logic [ADDR_W-1:0] pos_q, pos_d;
  logic              done_q, done_d;
  logic              out_valid_q, out_valid_d;
  out_word_t         out_q, out_d;

  logic              in_fire, hit, has_result;
  logic [ADDR_W-1:0] hit_addr;

  wps_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign sig_all = {cfg.signature_high, cfg.signature_low};

  // Clamp the length to one .. CELLS
  always_comb begin
    len_used = cfg.signature_length;
    if (len_used == '0) begin
      len_used = LEN_W'(1);
    end else if (len_used > LEN_W'(CELLS)) begin
      len_used = LEN_W'(CELLS);
    end
  end

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  assign cell_ctrl.shift = in_fire && !done_q;
  assign cell_ctrl.clear = in_fire && in_data_i.final_byte;

  // Build the chain; each cell picks the signature byte for its slot
  assign chain[0] = in_data_i.data_byte;

  for (genvar s = 0; s < CELLS; s++) begin : g_cell
    logic [LEN_W-1:0]     asc_idx;
    logic [SIG_IDX_W-1:0] sig_idx;
    logic                 in_use;

    assign asc_idx = len_used - LEN_W'(1) - LEN_W'(s);
    assign sig_idx = cfg.scan_descending ? SIG_IDX_W'(s) : asc_idx[SIG_IDX_W-1:0];
    assign in_use  = LEN_W'(s) < len_used;

    wps_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (cell_ctrl),
      .byte_i  (chain[s]),
      .sig_i   (sig_all[sig_idx*8 +: 8]),
      .wild_i  (cfg.wildcard_mask[sig_idx]),
      .use_i   (in_use),
      .byte_o  (chain[s+1]),
      .match_o (cell_match[s])
    );
  end

  // Saturate the fill count at the window depth
  assign seen_next = (seen_q < LEN_W'(CELLS)) ? seen_q + LEN_W'(1) : seen_q;
  assign hit       = !done_q && (seen_next >= len_used) && (&cell_match);

  // Lowest address covered by the match
  assign hit_addr = cfg.scan_descending ? cfg.base_address - pos_q
                  : cfg.base_address + pos_q - {{(ADDR_W-LEN_W){1'b0}}, len_used}
                    + ADDR_W'(1);

  assign has_result = in_fire && !done_q && (hit || in_data_i.final_byte);

  // Advance the search state; the final byte clears it
  always_comb begin
    seen_d = seen_q;
    pos_d  = pos_q;
    done_d = done_q;
    if (in_fire) begin
      if (in_data_i.final_byte) begin
        seen_d = '0;
        pos_d  = '0;
        done_d = 1'b0;
      end else if (!done_q) begin
        seen_d = seen_next;
        pos_d  = pos_q + ADDR_W'(1);
        done_d = hit;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
      pos_q  <= '0;
      done_q <= 1'b0;
    end else begin
      seen_q <= seen_d;
      pos_q  <= pos_d;
      done_q <= done_d;
    end
  end

  // Load the output register; drop valid when the word is taken
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (has_result) begin
      out_valid_d         = 1'b1;
      out_d.found         = hit;
      out_d.match_address = hit ? hit_addr : '0;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A finished search has seen at least one byte
  a_done_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> seen_q != '0)
    else $error("search done with empty window");

  // The final byte leaves a clean search state
  a_final_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_data_i.final_byte |=> pos_q == '0 && !done_q && seen_q == '0)
    else $error("final byte did not clear the search");

  // A not-found word carries a zero address
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.found |-> out_q.match_address == '0)
    else $error("not-found word with nonzero address");

  // The fill count never passes the window depth
  a_seen_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q <= LEN_W'(CELLS))
    else $error("fill count beyond window depth");

endmodule

FILE: dv/tb_wildcard_pattern_scan.sv
`timescale 1ns / 1ps
// Testbench for wildcard_pattern_scan: byte streams checked against a built-in
// scan predictor, with register setup over APB between phases.
// Depends on wps_pkg and the RTL of the block.
module tb_wildcard_pattern_scan;
  import wps_pkg::*;

  // Addresses past the last register; writes there must change nothing
  localparam logic [2:0] REG_SPARE     = 3'd6;
  localparam logic [2:0] REG_SPARE_TOP = 3'd7;

  localparam int ITEM_TARGET  = 1250;
  localparam int PHASE_ITEMS  = 100;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_LIMIT  = 5000;
  localparam int MAX_REPORTED = 10;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_e;

  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  in_word_t    in_data_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_word_t   out_data_o;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [5:0]  paddr       = '0;
  logic [63:0] pwdata      = '0;
  logic [63:0] prdata;
  logic        pready;

  wildcard_pattern_scan dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // Predictor copy of the registers and the search state
  cfg_t        cfg;
  logic [7:0]  win [CELLS];
  int unsigned held;
  logic [63:0] stream_pos;
  bit          scan_done;

  in_word_t  byte_q[$];
  out_word_t report_q[$];
  int        items_made   = 0;
  int        reports_seen = 0;
  int        errors       = 0;

  // Sender and receiver pacing
  bit       in_fire   = 1'b0;
  int       tx_burst  = 0;
  int       tx_gap    = 0;
  rx_mode_e rx_mode   = RX_OPEN;
  int       rx_left   = 0;
  bit       hold_long = 1'b0;
  bit       rx_rdy;
  out_word_t want;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  task automatic note_fault(string msg);
    errors++;
    if (errors <= MAX_REPORTED) $display("%0t ERROR %s", $time, msg);
  endtask

  function automatic logic [7:0] sig_byte(int i);
    logic [127:0] s;
    s = {cfg.signature_high, cfg.signature_low};
    return s[8 * i +: 8];
  endfunction

  // Zero counts as one, anything past the window as the full window
  function automatic int unsigned eff_len();
    int unsigned n;
    n = cfg.signature_length;
    if (n == 0) n = 1;
    if (n > CELLS) n = CELLS;
    return n;
  endfunction

  function automatic void clear_search();
    foreach (win[k]) win[k] = 8'h00;
    held       = 0;
    stream_pos = '0;
    scan_done  = 1'b0;
  endfunction

  // Advance the search by one accepted word, queue the report it causes
  function automatic void scan_predict(in_word_t w);
    out_word_t   r;
    int unsigned len;
    bit          hit;
    logic [63:0] at;
    if (scan_done) begin
      if (w.final_byte) clear_search();
      return;
    end
    for (int k = CELLS - 1; k > 0; k--) win[k] = win[k - 1];
    win[0] = w.data_byte;
    if (held < CELLS) held++;
    at = stream_pos;
    stream_pos = stream_pos + 64'd1;
    len = eff_len();
    hit = (held >= len);
    // Ascending: oldest window byte meets signature byte 0; descending: newest
    for (int i = 0; i < len; i++) begin
      if (!cfg.wildcard_mask[i] &&
          win[cfg.scan_descending ? i : len - 1 - i] != sig_byte(i)) hit = 1'b0;
    end
    if (hit) begin
      r.found = 1'b1;
      r.match_address = cfg.scan_descending ? cfg.base_address - at
                                            : cfg.base_address + at - 64'(len - 1);
      report_q.push_back(r);
      if (w.final_byte) clear_search();
      else scan_done = 1'b1;
    end else if (w.final_byte) begin
      r = '0;
      report_q.push_back(r);
      clear_search();
    end
  endfunction

  task automatic push_byte(logic [7:0] b, bit fin);
    in_word_t w;
    w.data_byte  = b;
    w.final_byte = fin;
    byte_q.push_back(w);
    items_made++;
  endtask

  // Write one register over APB: setup cycle, then access cycle
  task automatic cfg_write(logic [2:0] idx, logic [63:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_SIG_LOW:  cfg.signature_low    = value;
      REG_SIG_HIGH: cfg.signature_high   = value;
      REG_WILDCARD: cfg.wildcard_mask    = value[15:0];
      REG_LENGTH:   cfg.signature_length = value[LEN_W-1:0];
      REG_DESCEND:  cfg.scan_descending  = value[0];
      REG_BASE:     cfg.base_address     = value;
      default: ;
    endcase
  endtask

  // Wait until every word is taken and every report has come, then settle
  task automatic drain();
    int k;
    k = 0;
    while ((byte_q.size() != 0 || in_valid_i || report_q.size() != 0) &&
           k < DRAIN_LIMIT) begin
      @(posedge clk_i);
      k++;
    end
    repeat (4) @(negedge clk_i);
  endtask

  // Sender: bursts of words with random gaps, fed from byte_q
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_fire)) begin
      if (tx_gap > 0) begin
        tx_gap--;
        in_valid_i <= 1'b0;
      end else if (byte_q.size() > 0) begin
        in_data_i  <= byte_q.pop_front();
        in_valid_i <= 1'b1;
        if (tx_burst > 0) begin
          tx_burst--;
        end else begin
          tx_burst = $urandom_range(1, 60);
          tx_gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern that changes mode at random intervals
  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 120);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      RX_OPEN:     rx_rdy = 1'b1;
      RX_COIN:     rx_rdy = $urandom_range(0, 1);
      RX_SPARSE:   rx_rdy = ($urandom_range(0, 3) == 0);
      RX_PERIODIC: rx_rdy = rx_left[2];
      default:     rx_rdy = 1'b1;
    endcase
    out_ready_i <= rx_rdy && !hold_long;
  end

  // Hold off the receiver for a long stretch while words keep coming
  initial begin
    while (reports_seen < 20 || byte_q.size() < 40) @(posedge clk_i);
    hold_long = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_long = 1'b0;
  end

  // Monitor: check reports, run the predictor on every accepted word
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        reports_seen++;
        if (report_q.size() == 0) begin
          note_fault($sformatf("unexpected report found=%0b addr=%h",
                               out_data_o.found, out_data_o.match_address));
        end else begin
          want = report_q.pop_front();
          if (out_data_o.found !== want.found)
            note_fault($sformatf("found: expected %0b, got %0b",
                                 want.found, out_data_o.found));
          if (out_data_o.match_address !== want.match_address)
            note_fault($sformatf("match_address: expected %h, got %h",
                                 want.match_address, out_data_o.match_address));
        end
      end
      if (in_valid_i && in_ready_o) scan_predict(in_data_i);
    end
    in_fire = rst_ni && in_valid_i && in_ready_o;
  end

  // Stimulus
  initial begin
    logic [63:0] v;
    logic [7:0]  b;
    logic [7:0]  seq[$];
    int          len;
    int          pre;
    int          post;
    int          kind;
    int          pick;
    int          phase_start;
    int          idx;
    cfg = '0;
    cfg.signature_length = 1;
    clear_search();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset values: one signature byte of zero, ascending from address zero.
    // Miss, hit, ignored bytes, final after a hit, final miss, hit on final.
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h12, 1'b0);
    push_byte(8'h34, 1'b1);
    push_byte(8'hFF, 1'b1);
    push_byte(8'h00, 1'b1);
    drain();

    // Length zero acts as one; descending from zero wraps below the base
    cfg_write(REG_SIG_LOW, 64'h0123_4567_89AB_CDA5);
    cfg_write(REG_LENGTH, 64'h0);
    cfg_write(REG_DESCEND, 64'h1);
    cfg_write(REG_BASE, 64'h0);
    push_byte(8'h5A, 1'b0);
    push_byte(8'hA5, 1'b0);
    push_byte(8'h00, 1'b1);
    drain();

    // Length above sixteen capped, all wildcards, base at the top of memory
    cfg_write(REG_LENGTH, 64'hFFFF_FFFF_FFFF_FFF4);
    cfg_write(REG_WILDCARD, 64'hFFFF_FFFF_FFFF_FFFF);
    cfg_write(REG_DESCEND, 64'h2);
    cfg_write(REG_BASE, 64'hFFFF_FFFF_FFFF_FFFF);
    for (int k = 0; k < CELLS; k++) push_byte(k[0] ? 8'hFF : 8'h00, k == CELLS - 1);
    drain();

    // Random phases: new settings, then a batch of searches
    while (items_made < ITEM_TARGET) begin
      if ($urandom_range(0, 3) == 0)
        cfg_write($urandom_range(0, 1) ? REG_SPARE : REG_SPARE_TOP, {$urandom, $urandom});
      cfg_write(REG_SIG_LOW, {$urandom, $urandom});
      cfg_write(REG_SIG_HIGH, {$urandom, $urandom});
      v = {$urandom, $urandom};
      pick = $urandom_range(0, 3);
      case (pick)
        0: v[15:0] = 16'h0000;
        1: v[15:0] = 16'($urandom & $urandom & $urandom);
        2: v[15:0] = 16'($urandom);
        default: v[15:0] = 16'hFFFF;
      endcase
      cfg_write(REG_WILDCARD, v);
      v = {$urandom, $urandom};
      pick = $urandom_range(0, 9);
      case (pick)
        6: v[4:0] = 5'd1;
        7: v[4:0] = 5'd16;
        8: v[4:0] = 5'd0;
        9: v[4:0] = 5'($urandom_range(17, 31));
        default: v[4:0] = 5'($urandom_range(1, 16));
      endcase
      cfg_write(REG_LENGTH, v);
      v = {$urandom, $urandom};
      v[0] = $urandom_range(0, 1);
      cfg_write(REG_DESCEND, v);
      pick = $urandom_range(0, 9);
      case (pick)
        6: v = 64'($urandom_range(0, 20));
        7: v = ~64'($urandom_range(0, 20));
        8: v = '0;
        9: v = '1;
        default: v = {$urandom, $urandom};
      endcase
      cfg_write(REG_BASE, v);

      phase_start = items_made;
      while (items_made - phase_start < PHASE_ITEMS) begin
        seq.delete();
        len  = eff_len();
        kind = $urandom_range(0, 9);
        if (kind == 9) begin
          // Noise: random bytes, final marks anywhere or nowhere
          repeat ($urandom_range(1, 12))
            push_byte(8'($urandom), $urandom_range(0, 5) == 0);
        end else begin
          // Filler, often borrowing signature bytes to make near misses
          pre = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
          repeat (pre) begin
            b = ($urandom_range(0, 3) == 0) ? sig_byte($urandom_range(0, len - 1))
                                            : 8'($urandom);
            seq.push_back(b);
          end
          // Signature in stream order, wildcards filled at random
          if (kind <= 7) begin
            for (int j = 0; j < len; j++) begin
              idx = cfg.scan_descending ? len - 1 - j : j;
              seq.push_back(cfg.wildcard_mask[idx] ? 8'($urandom) : sig_byte(idx));
            end
            // Broken copy: flip one bit somewhere in the signature
            if (kind == 7) begin
              idx = seq.size() - 1 - $urandom_range(0, len - 1);
              seq[idx] = seq[idx] ^ (8'h01 << $urandom_range(0, 7));
            end
          end
          post = $urandom_range(0, 5);
          repeat (post) seq.push_back(8'($urandom));
          if (seq.size() == 0) seq.push_back(8'($urandom));
          foreach (seq[j]) push_byte(seq[j], j == seq.size() - 1);
        end
      end
      drain();
    end

    drain();
    repeat (8) @(negedge clk_i);
    if (report_q.size() != 0)
      note_fault($sformatf("%0d expected reports never came", report_q.size()));
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
